// ===== hw/rtl/urc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types and constants of the UTF-16 record cleaner.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int DEF_MAX_RECORD_CHARS = 1024;
  localparam int DEF_JUNK_ENTRIES     = 16;

  localparam int UNIT_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int TAB_W    = 11;
  localparam int JTOT_W   = 5;

  localparam logic [UNIT_W-1:0] UNIT_CR   = 16'h000D;
  localparam logic [UNIT_W-1:0] UNIT_LF   = 16'h000A;
  localparam logic [UNIT_W-1:0] UNIT_TAB  = 16'h0009;
  localparam logic [UNIT_W-1:0] UNIT_ZERO = 16'h0000;

  localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_LOW   = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_HIGH  = 8'h7F;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

  typedef enum logic {
    FUNC_UNIT = 1'b0,
    FUNC_END  = 1'b1
  } urc_func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_JUNK     = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_EOF      = 2'd3
  } urc_status_t;

  // Commands from the record control to the junk cell chain.
  typedef struct packed {
    logic clear;
    logic insert;
  } urc_chain_ctrl_t;

  // Status from the junk cell chain back to the record control.
  typedef struct packed {
    logic match;
    logic full;
  } urc_chain_stat_t;

endpackage : urc_pkg
`default_nettype wire

// ===== hw/rtl/urc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urc_in_if / urc_out_if
// Valid/ready channels of the UTF-16 record cleaner.
// ----------------------------------------------------------------------------
interface urc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] code_unit;

  modport source (output valid, output func, output code_unit, input ready);
  modport sink   (input valid, input func, input code_unit, output ready);
endinterface : urc_in_if

interface urc_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  char_byte;
  logic        record_end;
  logic [1:0]  record_status;
  logic [10:0] tab_total;
  logic [4:0]  junk_total;

  modport source (output valid, output char_valid, output char_byte, output record_end,
                  output record_status, output tab_total, output junk_total, input ready);
  modport sink   (input valid, input char_valid, input char_byte, input record_end,
                  input record_status, input tab_total, input junk_total, output ready);
endinterface : urc_out_if
`default_nettype wire

// ===== hw/rtl/urc_junk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urc_junk_cell
// One entry of the junk list: holds a value, compares it with the probe and
// takes its neighbor's entry when a new value is shifted in.
// ----------------------------------------------------------------------------
module urc_junk_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire urc_pkg::urc_chain_ctrl_t ctrl,
  input  wire logic [15:0]             probe,
  input  wire logic [15:0]             prev_value,
  input  wire logic                    prev_used,
  input  wire logic                    match_in,
  output logic [15:0]                  value,
  output logic                         used,
  output logic                         match_out
);
  import urc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      used <= 1'b0;
    end else if (ctrl.insert) begin
      used <= prev_used;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      value <= prev_value;
    end
  end

  assign match_out = match_in | (used & (value == probe));

endmodule : urc_junk_cell
`default_nettype wire

// ===== hw/rtl/urc_junk_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urc_junk_chain
// Row of junk cells. New values enter at the head and push the older ones
// one cell along; the match flag ripples from head to tail.
// ----------------------------------------------------------------------------
module urc_junk_chain #(
  parameter int JUNK_ENTRIES = urc_pkg::DEF_JUNK_ENTRIES
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire urc_pkg::urc_chain_ctrl_t ctrl,
  input  wire logic [15:0]              probe,
  output urc_pkg::urc_chain_stat_t      stat
);
  import urc_pkg::*;

  logic [15:0] value [JUNK_ENTRIES];
  logic        used  [JUNK_ENTRIES];
  logic        match [JUNK_ENTRIES];

  for (genvar i = 0; i < JUNK_ENTRIES; i++) begin : g_cell
    logic [15:0] prev_value;
    logic        prev_used;
    logic        match_in;

    if (i == 0) begin : g_head
      assign prev_value = probe;
      assign prev_used  = 1'b1;
      assign match_in   = 1'b0;
    end else begin : g_body
      assign prev_value = value[i-1];
      assign prev_used  = used[i-1];
      assign match_in   = match[i-1];
    end

    urc_junk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .probe      (probe),
      .prev_value (prev_value),
      .prev_used  (prev_used),
      .match_in   (match_in),
      .value      (value[i]),
      .used       (used[i]),
      .match_out  (match[i])
    );
  end

  assign stat.match = match[JUNK_ENTRIES-1];
  assign stat.full  = used[JUNK_ENTRIES-1];

endmodule : urc_junk_chain
`default_nettype wire

// ===== hw/rtl/utf16_record_cleaner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_record_cleaner_unit
// Cleans a UTF-16LE unit stream into ASCII bytes grouped into records.
// ----------------------------------------------------------------------------
// One code unit is taken per clock cycle; each transaction is settled in the
// cycle it is accepted and its result, if any, lands in the output register
// on the next edge. The junk list is a row of JUNK_ENTRIES cells compared in
// parallel against the incoming unit, so the rate stays one unit per cycle;
// the match ripple along that row sets the longest path. A new input
// transaction is accepted whenever the output register is empty or being
// drained. There is no clearing pass after reset.
module utf16_record_cleaner_unit #(
  parameter int MAX_RECORD_CHARS = urc_pkg::DEF_MAX_RECORD_CHARS,
  parameter int JUNK_ENTRIES     = urc_pkg::DEF_JUNK_ENTRIES
) (
  input wire logic clk,
  input wire logic rst,
  urc_in_if.sink   din,
  urc_out_if.source dout
);
  import urc_pkg::*;

  localparam int CW = $clog2(MAX_RECORD_CHARS + 1);
  localparam int JW = $clog2(JUNK_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECORD_CHARS);

  logic          cr_seen, cr_seen_next;
  logic          lf_seen, lf_seen_next;
  logic [CW-1:0] char_count, char_count_next;
  logic [CW-1:0] tab_count, tab_count_next;
  logic [JW-1:0] junk_count, junk_count_next;

  urc_chain_ctrl_t ctrl;
  urc_chain_stat_t stat;

  logic        accept;
  logic        has_result;
  logic        res_char_valid;
  logic [7:0]  res_byte;
  logic        res_end;
  urc_status_t res_status;

  logic [7:0]  lo, hi;
  logic        is_lf, is_tab, is_zero, is_cr, is_junk, keep;
  logic        cr_any, lf_any;
  logic [JW-1:0] junk_after;
  logic [CW-1:0] tab_after;

  assign din.ready = !dout.valid || dout.ready;
  assign accept    = din.valid && din.ready;

  assign lo      = din.code_unit[7:0];
  assign hi      = din.code_unit[15:8];
  assign is_lf   = (din.code_unit == UNIT_LF);
  assign is_tab  = (din.code_unit == UNIT_TAB);
  assign is_zero = (din.code_unit == UNIT_ZERO);
  assign is_cr   = (din.code_unit == UNIT_CR);
  assign is_junk = !is_lf && !is_tab && !is_zero && !is_cr &&
                   ((hi != 8'h00) || (lo < BYTE_LOW) || (lo > BYTE_HIGH));
  assign keep    = !is_zero && !is_cr;
  assign cr_any  = cr_seen || is_cr;
  assign lf_any  = lf_seen || is_lf;

  // Per-transaction decisions and next record state.
  always_comb begin
    ctrl.insert = accept && (din.func == FUNC_UNIT) && is_junk && !stat.match && !stat.full;
    junk_after  = junk_count + JW'(ctrl.insert);
    tab_after   = tab_count + CW'(lo == BYTE_TAB);

    has_result      = 1'b0;
    res_char_valid  = 1'b0;
    res_byte        = 8'h00;
    res_end         = 1'b0;
    res_status      = STAT_OK;
    ctrl.clear      = 1'b0;
    cr_seen_next    = cr_seen;
    lf_seen_next    = lf_seen;
    char_count_next = char_count;
    tab_count_next  = tab_count;
    junk_count_next = junk_count;
    if (accept) begin
      if (din.func == FUNC_END) begin
        has_result = 1'b1;
        res_end    = 1'b1;
        res_status = STAT_EOF;
        ctrl.clear = 1'b1;
      end else if (!keep) begin
        cr_seen_next = cr_any;
        if (cr_any && lf_any) begin
          has_result = 1'b1;
          res_end    = 1'b1;
          res_status = (junk_after != '0) ? STAT_JUNK : STAT_OK;
          ctrl.clear = 1'b1;
        end
      end else if (char_count >= MAX_COUNT) begin
        // The unit that would run past the limit is dropped; its junk entry
        // still counts in the reported total.
        has_result      = 1'b1;
        res_end         = 1'b1;
        res_status      = STAT_OVERFLOW;
        junk_count_next = junk_after;
        ctrl.clear      = 1'b1;
      end else begin
        has_result      = 1'b1;
        res_char_valid  = 1'b1;
        res_byte        = is_junk ? BYTE_SPACE : lo;
        lf_seen_next    = lf_any;
        tab_count_next  = tab_after;
        char_count_next = char_count + CW'(1);
        junk_count_next = junk_after;
        if (cr_any && lf_any) begin
          res_end    = 1'b1;
          res_status = (junk_after != '0) ? STAT_JUNK : STAT_OK;
          ctrl.clear = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      cr_seen    <= 1'b0;
      lf_seen    <= 1'b0;
      char_count <= '0;
      tab_count  <= '0;
      junk_count <= '0;
    end else begin
      cr_seen    <= cr_seen_next;
      lf_seen    <= lf_seen_next;
      char_count <= char_count_next;
      tab_count  <= tab_count_next;
      junk_count <= junk_count_next;
    end
  end

  urc_junk_chain #(
    .JUNK_ENTRIES (JUNK_ENTRIES)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .probe (din.code_unit),
    .stat  (stat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (accept && has_result) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      dout.char_valid    <= res_char_valid;
      dout.char_byte     <= res_byte;
      dout.record_end    <= res_end;
      dout.record_status <= res_status;
      dout.tab_total     <= TAB_W'(tab_count_next);
      dout.junk_total    <= JTOT_W'(junk_count_next);
    end
  end

endmodule : utf16_record_cleaner_unit
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 record cleaner. A short table of
// directed units is followed by generated records: mostly well-formed
// records with random content, some junk-heavy records, one long tab record
// that overflows, and random noise. Every accepted input transaction runs
// through a local model of the cleaner. Each output transaction is compared
// field by field with the oldest expected result. The sender idles in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import urc_pkg::*;

  localparam int MAX_CHARS   = DEF_MAX_RECORD_CHARS;
  localparam int JUNK_SLOTS  = DEF_JUNK_ENTRIES;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_AFTER  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  // Receiver stall modes.
  localparam int RDY_OPEN    = 0;
  localparam int RDY_MOSTLY  = 1;
  localparam int RDY_SPARSE  = 2;
  localparam int RDY_PATTERN = 3;

  typedef struct packed {
    logic              char_valid;
    logic [BYTE_W-1:0] char_byte;
    logic              record_end;
    urc_status_t       status;
    logic [TAB_W-1:0]  tab_total;
    logic [JTOT_W-1:0] junk_total;
  } clean_result_t;

  typedef struct packed {
    urc_func_t         func;
    logic [UNIT_W-1:0] unit;
    logic              typed;
    clean_result_t     exp;
  } dir_row_t;

  typedef struct {
    urc_func_t         func;
    logic [UNIT_W-1:0] unit;
    bit                typed;
    clean_result_t     exp;
    bit                drain;
  } unit_item_t;

  localparam clean_result_t NO_RES = '0;
  // First printable unit after reset: kept, nothing counted yet.
  localparam clean_result_t R_AFTER_RESET = {1'b1, 8'h41, 1'b0, STAT_OK, 11'd0, 5'd0};
  // CR closing a record whose LF came first: no byte, clean status.
  localparam clean_result_t R_PAIR_DROPPED = {1'b0, 8'h00, 1'b1, STAT_OK, 11'd0, 5'd0};
  // End of input right after a record end.
  localparam clean_result_t R_EOF_EMPTY = {1'b0, 8'h00, 1'b1, STAT_EOF, 11'd0, 5'd0};

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    {FUNC_UNIT, 16'h0041, 1'b1, R_AFTER_RESET},
    {FUNC_UNIT, 16'h0000, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h0020, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h007F, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h001F, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h0080, 1'b0, NO_RES},
    {FUNC_UNIT, 16'hFFFF, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h0109, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h0009, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h001F, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000D, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000A, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000A, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000D, 1'b1, R_PAIR_DROPPED},
    {FUNC_END,  16'hFFFF, 1'b1, R_EOF_EMPTY},
    {FUNC_UNIT, 16'h0061, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h8000, 1'b0, NO_RES},
    {FUNC_END,  16'h1234, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000D, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h0000, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h005A, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h000A, 1'b0, NO_RES},
    {FUNC_UNIT, 16'h00FF, 1'b0, NO_RES},
    {FUNC_END,  16'h0000, 1'b0, NO_RES}
  };

  localparam logic [UNIT_W-1:0] JUNK_POOL [4] = '{16'h0001, 16'h00FF, 16'hD800, 16'h0109};

  logic clk;
  logic rst;

  urc_in_if  in_ch ();
  urc_out_if out_ch ();

  utf16_record_cleaner_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model state of the record in progress.
  bit                cr_flag;
  bit                lf_flag;
  int                kept_chars;
  int                tab_run;
  logic [UNIT_W-1:0] junk_vals [JUNK_SLOTS];
  int                junk_n;

  unit_item_t    stim_q [$];
  clean_result_t pending_results [$];
  int            stim_idx;
  int            fail_count;
  int            cycle_count;
  bit            drain_next;

  int        burst_left;
  int        gap_left;
  int        rdy_mode;
  int        rdy_left;
  logic [7:0] stall_pat;

  function automatic void clear_record_model();
    cr_flag    = 1'b0;
    lf_flag    = 1'b0;
    kept_chars = 0;
    tab_run    = 0;
    junk_n     = 0;
    foreach (junk_vals[i]) junk_vals[i] = '0;
  endfunction

  function automatic void note_junk_unit(input logic [UNIT_W-1:0] u);
    for (int i = 0; i < junk_n; i++) begin
      if (junk_vals[i] == u) return;
    end
    if (junk_n < JUNK_SLOTS) begin
      junk_vals[junk_n] = u;
      junk_n++;
    end
  endfunction

  // Returns 1 when the unit produces a result, and fills it in.
  function automatic bit predict_clean(input urc_func_t f, input logic [UNIT_W-1:0] u,
                                       output clean_result_t res);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    bit keep;
    bit space;
    res   = '0;
    lo    = u[7:0];
    hi    = u[15:8];
    keep  = 1'b1;
    space = 1'b0;
    if (f == FUNC_END) begin
      res.record_end = 1'b1;
      res.status     = STAT_EOF;
      res.tab_total  = tab_run[TAB_W-1:0];
      res.junk_total = junk_n[JTOT_W-1:0];
      clear_record_model();
      return 1'b1;
    end
    if (u == UNIT_LF) begin
      lf_flag = 1'b1;
    end else if (u == UNIT_TAB) begin
      keep = 1'b1;
    end else if (u == UNIT_ZERO) begin
      keep = 1'b0;
    end else if (u == UNIT_CR) begin
      cr_flag = 1'b1;
      keep    = 1'b0;
    end else if (hi != 8'h00 || lo < BYTE_LOW || lo > BYTE_HIGH) begin
      note_junk_unit(u);
      space = 1'b1;
    end
    if (!keep) begin
      if (cr_flag && lf_flag) begin
        res.record_end = 1'b1;
        res.status     = (junk_n > 0) ? STAT_JUNK : STAT_OK;
        res.tab_total  = tab_run[TAB_W-1:0];
        res.junk_total = junk_n[JTOT_W-1:0];
        clear_record_model();
        return 1'b1;
      end
      return 1'b0;
    end
    if (kept_chars >= MAX_CHARS) begin
      res.record_end = 1'b1;
      res.status     = STAT_OVERFLOW;
      res.tab_total  = tab_run[TAB_W-1:0];
      res.junk_total = junk_n[JTOT_W-1:0];
      clear_record_model();
      return 1'b1;
    end
    if (lo == BYTE_TAB) tab_run++;
    kept_chars++;
    res.char_valid = 1'b1;
    res.char_byte  = space ? BYTE_SPACE : lo;
    res.tab_total  = tab_run[TAB_W-1:0];
    res.junk_total = junk_n[JTOT_W-1:0];
    if (cr_flag && lf_flag) begin
      res.record_end = 1'b1;
      res.status     = (junk_n > 0) ? STAT_JUNK : STAT_OK;
      clear_record_model();
    end
    return 1'b1;
  endfunction

  task automatic add_item(input urc_func_t f, input logic [UNIT_W-1:0] u,
                          input bit typed, input clean_result_t exp);
    unit_item_t it;
    it.func    = f;
    it.unit    = u;
    it.typed   = typed;
    it.exp     = exp;
    it.drain   = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(it);
  endtask

  task automatic add_unit(input logic [UNIT_W-1:0] u);
    add_item(FUNC_UNIT, u, 1'b0, NO_RES);
  endtask

  // Content of a record body: printable units mixed with tabs, zeros and junk.
  function automatic logic [UNIT_W-1:0] body_unit();
    int r;
    logic [UNIT_W-1:0] u;
    r = $urandom_range(0, 99);
    if (r < 45)      u = 16'($urandom_range(32, 127));
    else if (r < 55) u = UNIT_TAB;
    else if (r < 60) u = UNIT_ZERO;
    else if (r < 68) u = JUNK_POOL[$urandom_range(0, 3)];
    else if (r < 85) u = 16'($urandom);
    else if (r < 93) u = {8'h00, 8'($urandom_range(128, 255))};
    else             u = {8'h00, 8'($urandom_range(0, 31))};
    return u;
  endfunction

  task automatic add_line_end();
    int n;
    case ($urandom_range(0, 3))
      0: begin
        add_unit(UNIT_CR);
        add_unit(UNIT_LF);
      end
      1: begin
        add_unit(UNIT_LF);
        add_unit(UNIT_CR);
      end
      2: begin
        add_unit(UNIT_CR);
        add_unit(UNIT_ZERO);
        add_unit(UNIT_LF);
      end
      default: begin
        add_unit(UNIT_LF);
        n = $urandom_range(1, 4);
        repeat (n) add_unit(body_unit());
        add_unit(UNIT_CR);
      end
    endcase
  endtask

  task automatic build_random_records();
    int  kind;
    int  len;
    int  next_drain;
    bit  long_done;
    next_drain = stim_q.size();
    long_done  = 1'b0;
    drain_next = 1'b1;
    while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
      if (stim_q.size() >= next_drain + 250) begin
        next_drain = stim_q.size();
        drain_next = 1'b1;
      end
      if (!long_done && stim_q.size() > DIR_ROWS + LONG_AFTER) begin
        // A record of tab units runs the tab count to the character limit,
        // and the next one overflows it. Some of them carry a high byte, so
        // they are junk as well and fill the junk list with repeats.
        long_done = 1'b1;
        repeat (MAX_CHARS + 2) begin
          if ($urandom_range(0, 7) == 0) add_unit({8'($urandom_range(1, 255)), BYTE_TAB});
          else add_unit(UNIT_TAB);
        end
        add_line_end();
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(0, 20);
        repeat (len) add_unit(body_unit());
        add_line_end();
      end else if (kind < 80) begin
        len = $urandom_range(0, 12);
        repeat (len) add_unit(body_unit());
        add_item(FUNC_END, 16'($urandom), 1'b0, NO_RES);
      end else if (kind < 88) begin
        // More junk units than the list holds entries, with repeats.
        len = $urandom_range(JUNK_SLOTS + 1, JUNK_SLOTS + 8);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) add_unit(JUNK_POOL[$urandom_range(0, 3)]);
          else add_unit({8'($urandom_range(1, 255)), 8'($urandom)});
        end
        add_line_end();
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0) add_item(FUNC_END, 16'($urandom), 1'b0, NO_RES);
          else add_unit(16'($urandom));
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("[cycle %0d] %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
  endtask

  task automatic check_output();
    clean_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected", 16'(out_ch.char_byte), 16'h0);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.char_valid !== want.char_valid)
      report_mismatch("char_valid", 16'(out_ch.char_valid), 16'(want.char_valid));
    if (out_ch.char_byte !== want.char_byte)
      report_mismatch("char_byte", 16'(out_ch.char_byte), 16'(want.char_byte));
    if (out_ch.record_end !== want.record_end)
      report_mismatch("record_end", 16'(out_ch.record_end), 16'(want.record_end));
    if (out_ch.record_status !== want.status)
      report_mismatch("record_status", 16'(out_ch.record_status), 16'(want.status));
    if (out_ch.tab_total !== want.tab_total)
      report_mismatch("tab_total", 16'(out_ch.tab_total), 16'(want.tab_total));
    if (out_ch.junk_total !== want.junk_total)
      report_mismatch("junk_total", 16'(out_ch.junk_total), 16'(want.junk_total));
  endtask

  always @(posedge clk) begin : drive_and_check
    unit_item_t    cur;
    clean_result_t res;
    logic          next_valid;
    logic          next_ready;
    if (rst) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      cycle_count++;
      if (out_ch.valid && out_ch.ready) check_output();

      if (in_ch.valid && in_ch.ready) begin
        cur = stim_q[stim_idx];
        if (predict_clean(cur.func, cur.unit, res))
          pending_results.push_back(cur.typed ? cur.exp : res);
        stim_idx++;
      end

      // A transaction that was offered and not taken stays on the bus.
      next_valid = in_ch.valid && !in_ch.ready;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_idx < stim_q.size() &&
                     !(stim_q[stim_idx].drain && pending_results.size() != 0)) begin
          next_valid = 1'b1;
          in_ch.func      <= stim_q[stim_idx].func;
          in_ch.code_unit <= stim_q[stim_idx].unit;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_ch.valid <= next_valid;

      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(RDY_OPEN, RDY_PATTERN);
        rdy_left = $urandom_range(16, 160);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        RDY_OPEN:   next_ready = 1'b1;
        RDY_MOSTLY: next_ready = ($urandom_range(0, 3) != 0);
        RDY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
        default: begin
          stall_pat  = {stall_pat[6:0], stall_pat[7]};
          next_ready = stall_pat[0];
        end
      endcase
      out_ch.ready <= next_ready;
    end
  end

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_UNIT;
    in_ch.code_unit = '0;
    out_ch.ready    = 1'b0;
    stim_idx    = 0;
    fail_count  = 0;
    cycle_count = 0;
    drain_next  = 1'b0;
    burst_left  = $urandom_range(1, 40);
    gap_left    = 0;
    rdy_mode    = RDY_OPEN;
    rdy_left    = $urandom_range(16, 160);
    stall_pat   = 8'b1011_0010;
    clear_record_model();

    foreach (DIR_TABLE[i])
      add_item(DIR_TABLE[i].func, DIR_TABLE[i].unit, DIR_TABLE[i].typed, DIR_TABLE[i].exp);
    build_random_records();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!(stim_idx == stim_q.size() && pending_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS utf16_record_cleaner_unit");
    end else begin
      $display("FAIL utf16_record_cleaner_unit");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL utf16_record_cleaner_unit");
    $finish;
  end

endmodule : tb_top

// ===== files.f =====
hw/rtl/urc_pkg.sv
hw/rtl/urc_if.sv
hw/rtl/urc_junk_cell.sv
hw/rtl/urc_junk_chain.sv
hw/rtl/utf16_record_cleaner_unit.sv
sim/tb_top.sv
